// ----- sv/wwb_pkg.sv -----
// Package for the weighted window blur: constants, payload types, controller codes.
package wwb_pkg;

  localparam int MaxLine  = 1024;
  localparam int MaxRows  = 4096;
  localparam int ColW     = $clog2(MaxLine);
  localparam int RowW     = $clog2(MaxRows) + 1;
  localparam int WidthW   = 11;
  localparam int HeightW  = 13;
  localparam int WeightW  = 8;
  localparam int ChanW    = 8;
  localparam int PixW     = 3 * ChanW;
  localparam int SumW     = 20;
  localparam int TotW     = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCenter = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSide   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCorner = 3'd4;

  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             frame_last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_MAC,
    S_DIV,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic read;
    logic shift;
    logic mac_clear;
    logic mac_step;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic acts;
    logic draining;
    logic emit;
    logic mac_last;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- sv/wwb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wwb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/wwb_ctrl.sv -----
// Controller state machine of the weighted window blur.
module wwb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  wwb_pkg::dp_status_t status_i,
  output wwb_pkg::dp_cmd_t    cmd_o,
  output logic                in_stall_o
);

  wwb_pkg::ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wwb_pkg::S_IDLE: begin
        if (in_valid_i && status_i.acts) state_d = wwb_pkg::S_READ;
      end
      wwb_pkg::S_READ:  state_d = wwb_pkg::S_SHIFT;
      wwb_pkg::S_SHIFT: begin
        if (status_i.emit) state_d = wwb_pkg::S_MAC;
        else if (status_i.draining) state_d = wwb_pkg::S_READ;
        else state_d = wwb_pkg::S_IDLE;
      end
      wwb_pkg::S_MAC: begin
        if (status_i.mac_last) state_d = wwb_pkg::S_DIV;
      end
      wwb_pkg::S_DIV: begin
        if (status_i.div_last) state_d = wwb_pkg::S_OUT;
      end
      wwb_pkg::S_OUT: begin
        if (status_i.out_free) state_d = wwb_pkg::S_IDLE;
      end
      default: state_d = wwb_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      wwb_pkg::S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      wwb_pkg::S_READ:  cmd_o.read = 1'b1;
      wwb_pkg::S_SHIFT: begin
        cmd_o.shift     = 1'b1;
        cmd_o.mac_clear = status_i.emit;
      end
      wwb_pkg::S_MAC:   cmd_o.mac_step = 1'b1;
      wwb_pkg::S_DIV:   cmd_o.div_step = 1'b1;
      wwb_pkg::S_OUT:   cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wwb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/wwb_dp.sv -----
// Datapath of the weighted window blur: registers, line stores, window, MAC and divider.
module wwb_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [wwb_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [wwb_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wwb_pkg::in_item_t                in_data_i,
  input  logic                             out_stall_i,
  input  wwb_pkg::dp_cmd_t                 cmd_i,
  output wwb_pkg::dp_status_t              status_o,
  output logic                             out_valid_o,
  output wwb_pkg::out_item_t               out_data_o
);

  localparam int ColW  = wwb_pkg::ColW;
  localparam int RowW  = wwb_pkg::RowW;
  localparam int PixW  = wwb_pkg::PixW;
  localparam int ChanW = wwb_pkg::ChanW;
  localparam int SumW  = wwb_pkg::SumW;
  localparam int TotW  = wwb_pkg::TotW;

  // configuration
  logic [wwb_pkg::WidthW-1:0]  width_q, width_d;
  logic [wwb_pkg::HeightW-1:0] height_q, height_d;
  logic [wwb_pkg::WeightW-1:0] wc_q, wc_d, ws_q, ws_d, wk_q, wk_d;

  // positions
  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0] in_row_q, in_row_d;
  logic [RowW-2:0] out_row_q, out_row_d;
  logic            tail_q, tail_d;

  // item, window, arithmetic
  logic [PixW-1:0]                   pix_q, pix_d;
  logic                              drain_q, drain_d;
  logic [3:0][2:0][PixW-1:0]         win_q, win_d;
  logic [1:0]                        dr_q, dr_d, dc_q, dc_d;
  logic [2:0][SumW-1:0]              sum_q, sum_d;
  logic [TotW-1:0]                   tot_q, tot_d;
  logic [2:0]                        bit_q, bit_d;
  logic [2:0][ChanW-1:0]             quot_q, quot_d;
  logic                              out_valid_q, out_valid_d;
  wwb_pkg::out_item_t                out_q, out_d;

  logic [PixW-1:0] lower_rdata, upper_rdata;
  logic            ram_we;

  // effective geometry
  logic [ColW:0]          w_eff;
  logic [ColW-1:0]        w_last;
  logic [wwb_pkg::HeightW-1:0] h_eff;
  logic [RowW-2:0]        h_last;

  always_comb begin
    if (width_q == '0) w_eff = (ColW+1)'(1);
    else if (int'(width_q) > wwb_pkg::MaxLine) w_eff = (ColW+1)'(wwb_pkg::MaxLine);
    else w_eff = (ColW+1)'(width_q);
    if (height_q == '0) h_eff = wwb_pkg::HeightW'(1);
    else if (int'(height_q) > wwb_pkg::MaxRows) h_eff = wwb_pkg::HeightW'(wwb_pkg::MaxRows);
    else h_eff = height_q;
    w_last = ColW'(w_eff - (ColW+1)'(1));
    h_last = (RowW-1)'(h_eff - wwb_pkg::HeightW'(1));
  end

  // window tap under the MAC
  logic [1:0]             tap_col;
  logic [PixW-1:0]        tap_pix;
  logic                   tap_ok;
  logic [wwb_pkg::WeightW-1:0] tap_wt;
  logic                   out_last;

  always_comb begin
    tap_col = 2'd1 + dc_q;
    tap_ok  = (dr_q != 2'd0 || out_row_q != '0) && (dr_q != 2'd2 || out_row_q != h_last) &&
              (dc_q != 2'd0 || out_col_q != '0) && (dc_q != 2'd2 || out_col_q != w_last);
    tap_pix = tap_ok ? win_q[tap_col][dr_q] : '0;
    if (!tap_ok) tap_wt = '0;
    else if (dr_q == 2'd1 && dc_q == 2'd1) tap_wt = wc_q;
    else if (dr_q == 2'd1 || dc_q == 2'd1) tap_wt = ws_q;
    else tap_wt = wk_q;
    out_last = (out_row_q == h_last) && (out_col_q == w_last);
  end

  // status
  always_comb begin
    status_o.acts     = (in_data_i.opcode == wwb_pkg::OpPixel) || tail_q;
    status_o.draining = drain_q;
    status_o.emit     = (in_row_q >= RowW'(2)) || (in_row_q == RowW'(1) && in_col_q != '0);
    status_o.mac_last = (dr_q == 2'd2) && (dc_q == 2'd2);
    status_o.div_last = (bit_q == 3'd0);
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

  // line stores: lower holds the previous line, upper the one before
  assign ram_we = cmd_i.shift && !drain_q;

  wwb_ram #(.Width(PixW), .Depth(wwb_pkg::MaxLine)) u_lower (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_col_q),
    .wdata_i (pix_q),
    .re_i    (cmd_i.read),
    .raddr_i (in_col_q),
    .rdata_o (lower_rdata)
  );

  wwb_ram #(.Width(PixW), .Depth(wwb_pkg::MaxLine)) u_upper (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_col_q),
    .wdata_i (lower_rdata),
    .re_i    (cmd_i.read),
    .raddr_i (in_col_q),
    .rdata_o (upper_rdata)
  );

  // next values
  logic [SumW-1:0] cand;
  always_comb begin
    width_d = width_q; height_d = height_q;
    wc_d = wc_q; ws_d = ws_q; wk_d = wk_q;
    in_col_d = in_col_q; in_row_d = in_row_q;
    out_col_d = out_col_q; out_row_d = out_row_q; tail_d = tail_q;
    pix_d = pix_q; drain_d = drain_q; win_d = win_q;
    dr_d = dr_q; dc_d = dc_q; sum_d = sum_q; tot_d = tot_q;
    bit_d = bit_q; quot_d = quot_q; out_valid_d = out_valid_q; out_d = out_q;
    cand = SumW'(tot_q) << bit_q;

    // latch the item; a pixel after a finished frame starts a new one
    if (cmd_i.accept) begin
      pix_d   = {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
      drain_d = (in_data_i.opcode == wwb_pkg::OpDrain);
      if (in_data_i.opcode == wwb_pkg::OpPixel && tail_q) begin
        in_col_d = '0; in_row_d = '0; out_col_d = '0; out_row_d = '0; tail_d = 1'b0;
      end
    end

    // shift a new column into the window and advance the input position
    if (cmd_i.shift) begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = win_q[3];
      win_d[3] = {pix_q, lower_rdata, upper_rdata};
      if (in_col_q == w_last) begin
        in_col_d = '0;
        in_row_d = in_row_q + RowW'(1);
        if (!drain_q && in_row_q == RowW'(h_last)) tail_d = 1'b1;
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
    end

    if (cmd_i.mac_clear) begin
      sum_d = '0; tot_d = '0; dr_d = '0; dc_d = '0;
    end

    // accumulate one window tap per cycle
    if (cmd_i.mac_step) begin
      sum_d[2] = sum_q[2] + SumW'(16'(tap_pix[23:16]) * 16'(tap_wt));
      sum_d[1] = sum_q[1] + SumW'(16'(tap_pix[15:8]) * 16'(tap_wt));
      sum_d[0] = sum_q[0] + SumW'(16'(tap_pix[7:0]) * 16'(tap_wt));
      tot_d    = tot_q + TotW'(tap_wt);
      bit_d    = 3'd7;
      if (dc_q == 2'd2) begin
        dc_d = '0;
        dr_d = dr_q + 2'd1;
      end else begin
        dc_d = dc_q + 2'd1;
      end
    end

    // restoring division, one quotient bit per cycle, sums act as remainders
    if (cmd_i.div_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (sum_q[ch] >= cand) begin
          sum_d[ch]         = sum_q[ch] - cand;
          quot_d[ch][bit_q] = 1'b1;
        end else begin
          quot_d[ch][bit_q] = 1'b0;
        end
      end
      bit_d = bit_q - 3'd1;
    end

    // drop a transferred result
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    // load the result and advance the output position
    if (cmd_i.out_load) begin
      out_valid_d        = 1'b1;
      out_d.out_red      = (tot_q == '0) ? '0 : quot_d[2];
      out_d.out_green    = (tot_q == '0) ? '0 : quot_d[1];
      out_d.out_blue     = (tot_q == '0) ? '0 : quot_d[0];
      out_d.frame_last   = out_last;
      if (out_last) begin
        out_col_d = '0; out_row_d = '0; tail_d = 1'b0; in_col_d = '0; in_row_d = '0;
      end else if (out_col_q == w_last) begin
        out_col_d = '0;
        out_row_d = out_row_q + (RowW-1)'(1);
      end else begin
        out_col_d = out_col_q + ColW'(1);
      end
    end

    // register writes; geometry restarts the frame
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wwb_pkg::RegWidth: begin
          width_d = cfg_data_i[wwb_pkg::WidthW-1:0];
          in_col_d = '0; in_row_d = '0; out_col_d = '0; out_row_d = '0; tail_d = 1'b0;
        end
        wwb_pkg::RegHeight: begin
          height_d = cfg_data_i;
          in_col_d = '0; in_row_d = '0; out_col_d = '0; out_row_d = '0; tail_d = 1'b0;
        end
        wwb_pkg::RegCenter: wc_d = cfg_data_i[wwb_pkg::WeightW-1:0];
        wwb_pkg::RegSide:   ws_d = cfg_data_i[wwb_pkg::WeightW-1:0];
        wwb_pkg::RegCorner: wk_d = cfg_data_i[wwb_pkg::WeightW-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= wwb_pkg::WidthW'(1024);
      height_q    <= wwb_pkg::HeightW'(1024);
      wc_q        <= 8'd255;
      ws_q        <= 8'd220;
      wk_q        <= 8'd188;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      tail_q      <= 1'b0;
      drain_q     <= 1'b0;
      dr_q        <= '0;
      dc_q        <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      wc_q        <= wc_d;
      ws_q        <= ws_d;
      wk_q        <= wk_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      tail_q      <= tail_d;
      drain_q     <= drain_d;
      dr_q        <= dr_d;
      dc_q        <= dc_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    win_q  <= win_d;
    sum_q  <= sum_d;
    tot_q  <= tot_d;
    quot_q <= quot_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/weighted_window_blur.sv -----
// Top level of the weighted window blur: controller plus datapath.
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i / in_stall_o    in_data_i (opcode, in_red/green/blue)
//  out      output     out_valid_o / out_stall_i  out_data_o (out_red/green/blue, frame_last)
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A pixel that yields a result passes through the transfer, line store read, window shift,
// weight MAC over the nine taps, restoring divider and output load. A pixel without a result
// ends after the window shift; a drain item repeats read and shift until it yields a result.
// Reset sets the register defaults and clears positions; the line stores are not cleared.
// A result waits in the output register while the next item is worked on; the output
// load waits while that register is still stalled.
module weighted_window_blur (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  wwb_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output wwb_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wwb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wwb_pkg::CfgDataW-1:0] cfg_data_i
);

  wwb_pkg::dp_cmd_t    cmd;
  wwb_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  wwb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  wwb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sim/weighted_window_blur_test.sv -----
// Testbench for the weighted window blur: random frames checked against a local predictor.
`timescale 1ns / 100ps

module weighted_window_blur_test;

  // Predicts blurred pixels and holds them until the block delivers them.
  class blur_scoreboard;
    logic [wwb_pkg::WidthW-1:0]  width_reg;
    logic [wwb_pkg::HeightW-1:0] height_reg;
    logic [wwb_pkg::WeightW-1:0] wt_center, wt_side, wt_corner;
    logic [wwb_pkg::PixW-1:0]    upper_line[wwb_pkg::MaxLine];
    logic [wwb_pkg::PixW-1:0]    lower_line[wwb_pkg::MaxLine];
    logic [wwb_pkg::PixW-1:0]    evicted[2];
    int unsigned        in_col, in_row, out_idx;
    bit                 tail_open;
    wwb_pkg::out_item_t pending_px[$];
    int                 mismatches;
    int                 results_seen;

    function new();
      width_reg = 1024; height_reg = 1024;
      wt_center = 255; wt_side = 220; wt_corner = 188;
      evicted[0] = '0; evicted[1] = '0;
      restart();
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void restart();
      in_col = 0; in_row = 0; out_idx = 0; tail_open = 0;
      pending_px.delete();
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > wwb_pkg::MaxLine) return wwb_pkg::MaxLine;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > wwb_pkg::MaxRows) return wwb_pkg::MaxRows;
      return height_reg;
    endfunction

    function void write_reg(logic [wwb_pkg::CfgIdxW-1:0] idx,
                            logic [wwb_pkg::CfgDataW-1:0] val);
      case (idx)
        wwb_pkg::RegWidth:  begin width_reg = val[wwb_pkg::WidthW-1:0]; restart(); end
        wwb_pkg::RegHeight: begin height_reg = val[wwb_pkg::HeightW-1:0]; restart(); end
        wwb_pkg::RegCenter: wt_center = val[wwb_pkg::WeightW-1:0];
        wwb_pkg::RegSide:   wt_side = val[wwb_pkg::WeightW-1:0];
        wwb_pkg::RegCorner: wt_corner = val[wwb_pkg::WeightW-1:0];
        default: ;
      endcase
    endfunction

    // Pick a window pixel out of the new pixel, the line stores or the evicted pair.
    function logic [wwb_pkg::PixW-1:0] window_px(int unsigned t, int unsigned col,
                                                 int unsigned now, int unsigned w,
                                                 logic [wwb_pkg::PixW-1:0] newpix);
      int unsigned d;
      d = now - t;
      if (d == 0) return newpix;
      if (d <= w) return lower_line[col];
      if (d <= 2 * w) return upper_line[col];
      if (d == 2 * w + 1) return evicted[0];
      return evicted[1];
    endfunction

    function wwb_pkg::out_item_t blur_px(int unsigned q, int unsigned now,
                                         logic [wwb_pkg::PixW-1:0] newpix);
      int unsigned w, h, wt, sr, sg, sb, tot;
      int r, c, rr, cc;
      logic [wwb_pkg::PixW-1:0] p;
      wwb_pkg::out_item_t o;
      w = eff_w(); h = eff_h();
      r = q / w; c = q % w;
      sr = 0; sg = 0; sb = 0; tot = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = r + dr; cc = c + dc;
          if (rr >= 0 && cc >= 0 && rr < int'(h) && cc < int'(w)) begin
            if (dr == 0 && dc == 0) wt = wt_center;
            else if (dr == 0 || dc == 0) wt = wt_side;
            else wt = wt_corner;
            p = window_px(rr * w + cc, cc, now, w, newpix);
            sr += p[23:16] * wt;
            sg += p[15:8] * wt;
            sb += p[7:0] * wt;
            tot += wt;
          end
        end
      end
      if (tot == 0) begin
        o.out_red = '0; o.out_green = '0; o.out_blue = '0;
      end else begin
        o.out_red = 8'(sr / tot); o.out_green = 8'(sg / tot); o.out_blue = 8'(sb / tot);
      end
      o.frame_last = (q == w * h - 1);
      return o;
    endfunction

    // Advance the model by one accepted input transfer.
    function void note_input(wwb_pkg::in_item_t it);
      int unsigned w, h, n, now;
      logic [wwb_pkg::PixW-1:0] pix;
      w = eff_w(); h = eff_h(); n = w * h;
      if (it.opcode == wwb_pkg::OpDrain) begin
        if (tail_open) begin
          pending_px.push_back(blur_px(out_idx, n, '0));
          out_idx++;
          if (out_idx >= n) begin
            out_idx = 0;
            tail_open = 0;
          end
        end
        return;
      end
      // A pixel after a finished frame drops its tail and starts over.
      if (tail_open || in_col >= w || in_row >= h) begin
        in_col = 0; in_row = 0; out_idx = 0; tail_open = 0;
      end
      pix = {it.in_red, it.in_green, it.in_blue};
      now = in_row * w + in_col;
      if (now >= w + 1) begin
        pending_px.push_back(blur_px(now - w - 1, now, pix));
        out_idx++;
      end
      evicted[1] = evicted[0];
      evicted[0] = upper_line[in_col];
      upper_line[in_col] = lower_line[in_col];
      lower_line[in_col] = pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          tail_open = 1;
        end
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("ERROR %0t: result %0d %s got %0d expected %0d", $time, results_seen, what,
               got, want);
      mismatches++;
    endtask

    task check_result(wwb_pkg::out_item_t got);
      wwb_pkg::out_item_t want;
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected result, frame_last", got.frame_last, 0);
      end else begin
        want = pending_px.pop_front();
        if (got.out_red !== want.out_red) report_mismatch("red", got.out_red, want.out_red);
        if (got.out_green !== want.out_green)
          report_mismatch("green", got.out_green, want.out_green);
        if (got.out_blue !== want.out_blue)
          report_mismatch("blue", got.out_blue, want.out_blue);
        if (got.frame_last !== want.frame_last)
          report_mismatch("frame_last", got.frame_last, want.frame_last);
      end
      results_seen++;
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid;
  logic                         in_stall;
  wwb_pkg::in_item_t            in_data;
  logic                         out_valid;
  logic                         out_stall;
  wwb_pkg::out_item_t           out_data;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [wwb_pkg::CfgIdxW-1:0]  cfg_index;
  logic [wwb_pkg::CfgDataW-1:0] cfg_data;

  blur_scoreboard blur_sb;
  int items_sent;
  int pixels_sent;
  int drains_sent;
  int phases_run;
  bit held_off;

  weighted_window_blur dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hang guard.
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", blur_sb.pending_px.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side: check each transfer, stall at random outside a stall-free stretch, hold off once for a long stretch.
  initial begin
    int hold_cycles;
    hold_cycles = 0;
    held_off = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) blur_sb.check_result(out_data);
      if (!held_off && blur_sb.results_seen >= 150) begin
        held_off = 1;
        hold_cycles = 500;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (blur_sb.results_seen >= 400 && blur_sb.results_seen < 700) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 10);
      end
    end
  end

  // Offer one item, with a random gap first, and hold it until it is taken.
  task send_item(wwb_pkg::in_item_t it);
    int gap;
    gap = 0;
    if (!(items_sent >= 600 && items_sent < 900) && $urandom_range(0, 99) < 10)
      gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    blur_sb.note_input(it);
    items_sent++;
    if (it.opcode == wwb_pkg::OpDrain) drains_sent++;
    else pixels_sent++;
  endtask

  task send_pixel();
    wwb_pkg::in_item_t it;
    it.opcode = wwb_pkg::OpPixel;
    it.in_red = $urandom;
    it.in_green = $urandom;
    it.in_blue = $urandom;
    if ($urandom_range(0, 9) == 0) it.in_red = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 9) == 0) it.in_green = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 9) == 0) it.in_blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
    send_item(it);
  endtask

  task send_drain();
    wwb_pkg::in_item_t it;
    it.opcode = wwb_pkg::OpDrain;
    it.in_red = $urandom;
    it.in_green = $urandom;
    it.in_blue = $urandom;
    send_item(it);
  endtask

  // Wait until the block has gone quiet, then write one register.
  task write_reg(logic [wwb_pkg::CfgIdxW-1:0] idx, int val);
    in_valid <= 1'b0;
    while (blur_sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= wwb_pkg::CfgDataW'(val);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    blur_sb.write_reg(idx, wwb_pkg::CfgDataW'(val));
  endtask

  task set_geometry(int w, int h, int wc, int ws, int wk);
    write_reg(wwb_pkg::RegWidth, w);
    write_reg(wwb_pkg::RegHeight, h);
    write_reg(wwb_pkg::RegCenter, wc);
    write_reg(wwb_pkg::RegSide, ws);
    write_reg(wwb_pkg::RegCorner, wk);
    phases_run++;
  endtask

  // One frame of pixels with a stray drain now and then, then a tail of drains that may be cut short or overlong.
  task run_frame(int w, int h);
    int drains;
    drains = w + 1;
    case ($urandom_range(0, 9))
      0: drains = $urandom_range(0, w);
      1: drains = w + 1 + $urandom_range(1, 3);
      default: ;
    endcase
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 49) == 0) send_drain();
      send_pixel();
    end
    repeat (drains) send_drain();
  endtask

  function int rand_weight();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    int w, h;
    blur_sb = new();
    items_sent = 0; pixels_sent = 0; drains_sent = 0; phases_run = 0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults: a drain with nothing pending, then a few pixels of a wide frame.
    send_drain();
    repeat (6) send_pixel();
    // Zero total weight on a small frame.
    set_geometry(3, 3, 0, 0, 0);
    run_frame(3, 3);
    // Full weights on a 2x2 frame, then a tiny frame of one pixel.
    set_geometry(2, 2, 255, 255, 255);
    run_frame(2, 2);
    set_geometry(1, 1, 255, 0, 0);
    run_frame(1, 1);
    // Out-of-range geometry: zero and oversize widths and heights act as the clamped values.
    set_geometry(0, 8191, rand_weight(), rand_weight(), rand_weight());
    repeat (12) send_pixel();
    set_geometry(2047, 0, rand_weight(), rand_weight(), rand_weight());
    repeat (5) send_pixel();
    set_geometry(1024, 4096, 0, 255, 0);
    repeat (5) send_pixel();

    // Random frames, mostly small.
    while (items_sent < 1950) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(7, 40);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
      end
      set_geometry(w, h, rand_weight(), rand_weight(), rand_weight());
      repeat ($urandom_range(1, 3)) run_frame(w, h);
    end

    in_valid <= 1'b0;
    while (blur_sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Covered %0d pixels and %0d drains over %0d register settings,", pixels_sent,
             drains_sent, phases_run);
    $display("with %0d blurred pixels compared and one long output hold-off.",
             blur_sb.results_seen);
    if (blur_sb.mismatches == 0 && blur_sb.pending_px.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
